// ===== sv/rv64is_pkg.sv =====
// Shared opcodes, field codes, exit codes and helper types of the RV64IM step unit.
package rv64is_pkg;

    localparam int IMG_ADDR_W = 16;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] OP_IMM32  = 7'h1B;
    localparam logic [6:0] OP_REG32  = 7'h3B;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [5:0] F6_ALT    = 6'h10;

    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_REM    = 3'd6;

    typedef enum logic [1:0] {
        EXIT_RUN     = 2'd0,
        EXIT_ECALL   = 2'd1,
        EXIT_EBREAK  = 2'd2,
        EXIT_ILLEGAL = 2'd3
    } t_exit;

    // multiply/divide command: funct3 and the 32-bit (W) form
    typedef struct packed {
        logic [2:0] f3;
        logic       word;
    } t_md_cmd;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

// ===== sv/rv64is_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rv64is_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rv64is_muldiv.sv =====
// Iterative radix-2 multiply and restoring divide unit for the M extension.
module rv64is_muldiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rv64is_pkg::t_md_cmd  i_cmd,
    input  logic [63:0]          i_a,
    input  logic [63:0]          i_b,
    output logic                 o_done,
    output logic [63:0]          o_result
);

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} t_mstate;

    t_mstate             r_state;
    rv64is_pkg::t_md_cmd r_cmd;
    logic [63:0]         r_hi, r_lo, r_mcand, r_corr, r_a_orig;
    logic                r_bz, r_neg_q, r_neg_r;
    logic [5:0]          r_cnt;
    logic                r_done;
    logic [63:0]         r_result;

    logic        s_is_div, s_sgn, s_na, s_nb;
    logic [63:0] s_aval, s_bval, s_ma, s_mb, s_corr;
    logic [64:0] s_msum, s_rem_sh, s_diff;
    logic [63:0] s_q, s_r, s_res;

    // operand setup
    always_comb begin
        s_is_div = i_cmd.f3[2];
        s_sgn    = s_is_div && !i_cmd.f3[0];
        if (i_cmd.word) begin
            s_aval = s_sgn ? rv64is_pkg::sext32(i_a[31:0]) : {32'd0, i_a[31:0]};
            s_bval = s_sgn ? rv64is_pkg::sext32(i_b[31:0]) : {32'd0, i_b[31:0]};
        end else begin
            s_aval = i_a;
            s_bval = i_b;
        end
        s_na = s_sgn && s_aval[63];
        s_nb = s_sgn && s_bval[63];
        s_ma = s_na ? (64'd0 - s_aval) : s_aval;
        s_mb = s_nb ? (64'd0 - s_bval) : s_bval;
        case (i_cmd.f3)
            rv64is_pkg::F3_MULH:   s_corr = (i_a[63] ? i_b : 64'd0) + (i_b[63] ? i_a : 64'd0);
            rv64is_pkg::F3_MULHSU: s_corr = i_a[63] ? i_b : 64'd0;
            default:               s_corr = 64'd0;
        endcase
    end

    // one iteration step
    always_comb begin
        s_msum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : 65'd0);
        s_rem_sh = {r_hi, r_lo[63]};
        s_diff   = s_rem_sh - {1'b0, r_mcand};
    end

    // final selection
    always_comb begin
        s_q = r_neg_q ? (64'd0 - r_lo) : r_lo;
        s_r = r_neg_r ? (64'd0 - r_hi) : r_hi;
        if (r_cmd.f3[2]) begin
            if (r_bz) begin
                s_res = r_cmd.f3[1] ? r_a_orig : '1;
            end else begin
                s_res = r_cmd.f3[1] ? s_r : s_q;
            end
        end else begin
            case (r_cmd.f3)
                rv64is_pkg::F3_MUL:   s_res = r_lo;
                rv64is_pkg::F3_MULHU: s_res = r_hi;
                default:              s_res = r_hi - r_corr;
            endcase
        end
        if (r_cmd.word) begin
            s_res = rv64is_pkg::sext32(s_res[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_cmd    <= i_cmd;
                        r_hi     <= 64'd0;
                        r_cnt    <= 6'd63;
                        r_corr   <= s_corr;
                        r_a_orig <= s_aval;
                        r_bz     <= (s_bval == 64'd0);
                        r_neg_q  <= s_na ^ s_nb;
                        r_neg_r  <= s_na;
                        r_lo     <= s_is_div ? s_ma : s_aval;
                        r_mcand  <= s_is_div ? s_mb : s_bval;
                        r_state  <= M_RUN;
                    end
                end
                M_RUN: begin
                    if (r_cmd.f3[2]) begin
                        r_hi <= !s_diff[64] ? s_diff[63:0] : s_rem_sh[63:0];
                        r_lo <= {r_lo[62:0], !s_diff[64]};
                    end else begin
                        r_hi <= s_msum[64:1];
                        r_lo <= {s_msum[0], r_lo[63:1]};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= M_FIN;
                    end
                end
                M_FIN: begin
                    r_result <= s_res;
                    r_done   <= 1'b1;
                    r_state  <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == M_IDLE)
        else $error("muldiv started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == M_IDLE && $past(r_state) == M_FIN)
        else $error("muldiv done outside finish");

endmodule

// ===== sv/rv64im_instruction_step_unit.sv =====
// Top level of the RV64IM step unit: sequencer, byte memory, register file, multiply/divide unit and result register.
// After reset the unit sweeps all 2^ADDR_BITS bytes of the byte memory to zero, one byte a
// cycle, and holds o_stall high meanwhile. Each item is then worked on alone: the single
// byte port of the memory sets the pace, one byte per cycle. An image write does 8 byte
// writes. An execute step fetches the four instruction bytes, reads rs1 and rs2 from the
// register file RAM one after the other and executes; a load then reads its bytes, a
// store writes its bytes, and multiply, divide and remainder run on the iterative unit.
// The next item is taken while a finished result still waits in the output register.
module rv64im_instruction_step_unit #(
    parameter int ADDR_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic [rv64is_pkg::IMG_ADDR_W-1:0] i_image_addr,
    input  logic [63:0]                       i_image_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_exit_code,
    output logic [63:0]                       o_insn_pc,
    output logic [31:0]                       o_insn_word,
    output logic                              o_reg_written,
    output logic [4:0]                        o_dest_index,
    output logic [63:0]                       o_dest_value,
    output logic [63:0]                       o_next_pc
);

    localparam int SUM_W = (ADDR_BITS > rv64is_pkg::IMG_ADDR_W) ? ADDR_BITS
                                                                 : rv64is_pkg::IMG_ADDR_W + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_IMG, S_FETCH, S_RS1, S_RS2, S_EXEC, S_LOAD, S_STORE, S_MD, S_FIN
    } t_state;

    typedef enum logic [1:0] {K_ALU, K_LOAD, K_STORE, K_MD} t_kind;

    t_state                          r_state;
    logic [ADDR_BITS-1:0]            r_clr;
    logic [63:0]                     r_pc, r_npc, r_val, r_a, r_b, r_data;
    logic [31:0]                     r_insn;
    logic                            r_wb;
    rv64is_pkg::t_exit               r_exit;
    logic [ADDR_BITS-1:0]            r_addr;
    logic [3:0]                      r_cnt, r_nbytes;
    logic                            r_rdv;
    logic [2:0]                      r_rdi;
    logic [rv64is_pkg::IMG_ADDR_W-1:0] r_img_addr;
    logic [63:0]                     r_img_word;
    logic [31:0]                     r_rf_vld;
    logic                            r_md_start;
    logic                            r_out_valid;
    logic [1:0]                      r_o_exit;
    logic [63:0]                     r_o_pc, r_o_val, r_o_npc;
    logic [31:0]                     r_o_insn;
    logic                            r_o_wb;
    logic [4:0]                      r_o_rd;

    // memory ports
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [7:0]           mem_wdata, mem_rdata;
    logic                 rf_we;
    logic [4:0]           rf_waddr, rf_raddr;
    logic [63:0]          rf_rdata;
    logic [SUM_W-1:0]     img_sum;

    logic        rd_issue, rd_done, slot_free;
    logic [63:0] w_data, w_rf, ld_val;
    logic        md_done;
    logic [63:0] md_result;
    rv64is_pkg::t_md_cmd md_cmd;

    // instruction fields
    logic [6:0]  op, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [63:0] ii, si, bi, ui, ji, pc4;

    // execute decode
    logic [63:0]       e_val, e_npc, e_ld_addr, e_st_addr;
    logic              e_wb, e_ill, e_taken;
    rv64is_pkg::t_exit e_exit;
    t_kind             e_kind;
    logic [31:0]       aw, bw;

    assign op  = r_insn[6:0];
    assign rd  = r_insn[11:7];
    assign f3  = r_insn[14:12];
    assign rs1 = r_insn[19:15];
    assign rs2 = r_insn[24:20];
    assign f7  = r_insn[31:25];
    assign ii  = {{52{r_insn[31]}}, r_insn[31:20]};
    assign si  = {{52{r_insn[31]}}, r_insn[31:25], r_insn[11:7]};
    assign bi  = {{51{r_insn[31]}}, r_insn[31], r_insn[7], r_insn[30:25], r_insn[11:8], 1'b0};
    assign ui  = {{32{r_insn[31]}}, r_insn[31:12], 12'd0};
    assign ji  = {{43{r_insn[31]}}, r_insn[31], r_insn[19:12], r_insn[20], r_insn[30:21],
                  1'b0};
    assign pc4 = r_pc + 64'd4;
    assign aw  = r_a[31:0];
    assign bw  = w_rf[31:0];

    assign slot_free = !r_out_valid || !i_stall;
    assign img_sum   = SUM_W'(r_img_addr) + SUM_W'(r_cnt);
    assign rd_issue  = (r_state == S_FETCH || r_state == S_LOAD) && (r_cnt < r_nbytes);
    assign rd_done   = r_rdv && ({1'b0, r_rdi} == r_nbytes - 4'd1);
    assign w_data    = r_data | (64'(mem_rdata) << {r_rdi, 3'b000});
    // entries never written read as zero
    assign w_rf      = r_rf_vld[rf_raddr_q()] ? rf_rdata : 64'd0;

    function automatic logic [4:0] rf_raddr_q();
        return (r_state == S_RS2) ? rs1 : rs2;
    endfunction

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr + ADDR_BITS'(r_cnt);
        mem_wdata = 8'(r_b >> {r_cnt[2:0], 3'b000});
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 8'd0;
            end
            S_IMG: begin
                mem_we    = 1'b1;
                mem_waddr = img_sum[ADDR_BITS-1:0];
                mem_wdata = 8'(r_img_word >> {r_cnt[2:0], 3'b000});
            end
            S_STORE: mem_we = 1'b1;
            default: mem_we = 1'b0;
        endcase
        mem_raddr = r_addr + ADDR_BITS'(r_cnt);
        rf_raddr  = (r_state == S_RS1) ? rs1 : rs2;
        rf_we     = (r_state == S_FIN) && slot_free && (r_exit == rv64is_pkg::EXIT_RUN) &&
                    r_wb && (rd != 5'd0);
        rf_waddr  = rd;
    end

    always_comb begin
        unique case (f3[1:0])
            2'd0:    ld_val = f3[2] ? {56'd0, w_data[7:0]}  : {{56{w_data[7]}}, w_data[7:0]};
            2'd1:    ld_val = f3[2] ? {48'd0, w_data[15:0]} : {{48{w_data[15]}}, w_data[15:0]};
            2'd2:    ld_val = f3[2] ? {32'd0, w_data[31:0]} : rv64is_pkg::sext32(w_data[31:0]);
            default: ld_val = w_data;
        endcase
    end

    always_comb begin
        e_val     = 64'd0;
        e_npc     = pc4;
        e_wb      = 1'b0;
        e_ill     = 1'b0;
        e_exit    = rv64is_pkg::EXIT_RUN;
        e_kind    = K_ALU;
        e_taken   = 1'b0;
        e_ld_addr = r_a + ii;
        e_st_addr = r_a + si;
        unique case (op)
            rv64is_pkg::OP_LUI: begin
                e_wb  = 1'b1;
                e_val = ui;
            end
            rv64is_pkg::OP_AUIPC: begin
                e_wb  = 1'b1;
                e_val = r_pc + ui;
            end
            rv64is_pkg::OP_JAL: begin
                e_wb  = 1'b1;
                e_val = pc4;
                e_npc = r_pc + ji;
            end
            rv64is_pkg::OP_JALR: begin
                if (f3 != 3'd0) begin
                    e_ill = 1'b1;
                end else begin
                    e_wb  = 1'b1;
                    e_val = pc4;
                    e_npc = (r_a + ii) & ~64'd1;
                end
            end
            rv64is_pkg::OP_BRANCH: begin
                unique case (f3)
                    3'd0:    e_taken = (r_a == w_rf);
                    3'd1:    e_taken = (r_a != w_rf);
                    3'd4:    e_taken = $signed(r_a) < $signed(w_rf);
                    3'd5:    e_taken = !($signed(r_a) < $signed(w_rf));
                    3'd6:    e_taken = r_a < w_rf;
                    3'd7:    e_taken = r_a >= w_rf;
                    default: e_ill = 1'b1;
                endcase
                if (e_taken) begin
                    e_npc = r_pc + bi;
                end
            end
            rv64is_pkg::OP_LOAD: begin
                if (f3 == 3'd7) begin
                    e_ill = 1'b1;
                end else begin
                    e_wb   = 1'b1;
                    e_kind = K_LOAD;
                end
            end
            rv64is_pkg::OP_STORE: begin
                if (f3[2]) begin
                    e_ill = 1'b1;
                end else begin
                    e_kind = K_STORE;
                end
            end
            rv64is_pkg::OP_IMM: begin
                e_wb = 1'b1;
                unique case (f3)
                    3'd0: e_val = r_a + ii;
                    3'd2: e_val = {63'd0, $signed(r_a) < $signed(ii)};
                    3'd3: e_val = {63'd0, r_a < ii};
                    3'd4: e_val = r_a ^ ii;
                    3'd6: e_val = r_a | ii;
                    3'd7: e_val = r_a & ii;
                    3'd1: begin
                        if (r_insn[31:26] != 6'd0) e_ill = 1'b1;
                        else e_val = r_a << r_insn[25:20];
                    end
                    default: begin
                        if (r_insn[31:26] == 6'd0) e_val = r_a >> r_insn[25:20];
                        else if (r_insn[31:26] == rv64is_pkg::F6_ALT)
                            e_val = $signed(r_a) >>> r_insn[25:20];
                        else e_ill = 1'b1;
                    end
                endcase
            end
            rv64is_pkg::OP_REG: begin
                e_wb = 1'b1;
                if (f7 == rv64is_pkg::F7_MULDIV) begin
                    e_kind = K_MD;
                end else if (f7 == rv64is_pkg::F7_ALT) begin
                    if (f3 == 3'd0) e_val = r_a - w_rf;
                    else if (f3 == 3'd5) e_val = $signed(r_a) >>> w_rf[5:0];
                    else e_ill = 1'b1;
                end else if (f7 == rv64is_pkg::F7_BASE) begin
                    unique case (f3)
                        3'd0:    e_val = r_a + w_rf;
                        3'd1:    e_val = r_a << w_rf[5:0];
                        3'd2:    e_val = {63'd0, $signed(r_a) < $signed(w_rf)};
                        3'd3:    e_val = {63'd0, r_a < w_rf};
                        3'd4:    e_val = r_a ^ w_rf;
                        3'd5:    e_val = r_a >> w_rf[5:0];
                        3'd6:    e_val = r_a | w_rf;
                        default: e_val = r_a & w_rf;
                    endcase
                end else begin
                    e_ill = 1'b1;
                end
            end
            rv64is_pkg::OP_FENCE: e_val = 64'd0;
            rv64is_pkg::OP_SYSTEM: begin
                if (f3 != 3'd0 || rs1 != 5'd0 || rd != 5'd0) e_ill = 1'b1;
                else if (r_insn[31:20] == 12'd0) e_exit = rv64is_pkg::EXIT_ECALL;
                else if (r_insn[31:20] == 12'd1) e_exit = rv64is_pkg::EXIT_EBREAK;
                else e_ill = 1'b1;
            end
            rv64is_pkg::OP_IMM32: begin
                e_wb = 1'b1;
                if (f3 == 3'd0) e_val = rv64is_pkg::sext32(aw + ii[31:0]);
                else if (f3 == 3'd1 && f7 == rv64is_pkg::F7_BASE)
                    e_val = rv64is_pkg::sext32(aw << r_insn[24:20]);
                else if (f3 == 3'd5 && f7 == rv64is_pkg::F7_BASE)
                    e_val = rv64is_pkg::sext32(aw >> r_insn[24:20]);
                else if (f3 == 3'd5 && f7 == rv64is_pkg::F7_ALT)
                    e_val = rv64is_pkg::sext32($signed(aw) >>> r_insn[24:20]);
                else e_ill = 1'b1;
            end
            rv64is_pkg::OP_REG32: begin
                e_wb = 1'b1;
                if (f7 == rv64is_pkg::F7_MULDIV) begin
                    if (f3 == 3'd0 || f3[2]) e_kind = K_MD;
                    else e_ill = 1'b1;
                end else if (f7 == rv64is_pkg::F7_BASE) begin
                    if (f3 == 3'd0) e_val = rv64is_pkg::sext32(aw + bw);
                    else if (f3 == 3'd1) e_val = rv64is_pkg::sext32(aw << bw[4:0]);
                    else if (f3 == 3'd5) e_val = rv64is_pkg::sext32(aw >> bw[4:0]);
                    else e_ill = 1'b1;
                end else if (f7 == rv64is_pkg::F7_ALT) begin
                    if (f3 == 3'd0) e_val = rv64is_pkg::sext32(aw - bw);
                    else if (f3 == 3'd5) e_val = rv64is_pkg::sext32($signed(aw) >>> bw[4:0]);
                    else e_ill = 1'b1;
                end else begin
                    e_ill = 1'b1;
                end
            end
            default: e_ill = 1'b1;
        endcase
        if (e_ill) begin
            e_exit = rv64is_pkg::EXIT_ILLEGAL;
            e_kind = K_ALU;
        end
    end

    assign md_cmd.f3   = f3;
    assign md_cmd.word = (op == rv64is_pkg::OP_REG32);

    rv64is_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_bytes (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rv64is_ram #(.WIDTH(64), .DEPTH(32)) u_regs (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (r_val),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    rv64is_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_md_start),
        .i_cmd    (md_cmd),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (md_done),
        .o_result (md_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pc        <= 64'd0;
            r_rf_vld    <= 32'd0;
            r_out_valid <= 1'b0;
            r_rdv       <= 1'b0;
            r_md_start  <= 1'b0;
        end else begin
            r_md_start <= 1'b0;
            r_rdv      <= rd_issue;
            r_rdi      <= r_cnt[2:0];
            if (r_rdv) begin
                r_data <= w_data;
            end
            // drop the result once it transfers
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cnt  <= 4'd0;
                        r_data <= 64'd0;
                        if (i_func) begin
                            r_addr   <= r_pc[ADDR_BITS-1:0];
                            r_nbytes <= 4'd4;
                            r_state  <= S_FETCH;
                        end else begin
                            r_img_addr <= i_image_addr;
                            r_img_word <= i_image_word;
                            r_state    <= S_IMG;
                        end
                    end
                end
                S_IMG: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        r_insn  <= 32'd0;
                        r_exit  <= rv64is_pkg::EXIT_RUN;
                        r_wb    <= 1'b0;
                        r_val   <= 64'd0;
                        r_npc   <= r_pc;
                        r_state <= S_FIN;
                    end
                end
                S_FETCH: begin
                    if (rd_issue) begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                    if (rd_done) begin
                        r_insn  <= w_data[31:0];
                        r_state <= S_RS1;
                    end
                end
                S_RS1: r_state <= S_RS2;
                S_RS2: begin
                    r_a     <= w_rf;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_b    <= w_rf;
                    r_val  <= e_val;
                    r_npc  <= e_npc;
                    r_wb   <= e_wb;
                    r_exit <= e_exit;
                    r_cnt  <= 4'd0;
                    r_data <= 64'd0;
                    unique case (e_kind)
                        K_LOAD: begin
                            r_addr   <= e_ld_addr[ADDR_BITS-1:0];
                            r_nbytes <= 4'd1 << f3[1:0];
                            r_state  <= S_LOAD;
                        end
                        K_STORE: begin
                            r_addr   <= e_st_addr[ADDR_BITS-1:0];
                            r_nbytes <= 4'd1 << f3[1:0];
                            r_state  <= S_STORE;
                        end
                        K_MD: begin
                            r_md_start <= 1'b1;
                            r_state    <= S_MD;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_LOAD: begin
                    if (rd_issue) begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                    if (rd_done) begin
                        r_val   <= ld_val;
                        r_state <= S_FIN;
                    end
                end
                S_STORE: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == r_nbytes - 4'd1) begin
                        r_state <= S_FIN;
                    end
                end
                S_MD: begin
                    if (md_done) begin
                        r_val   <= md_result;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_o_exit    <= r_exit;
                        r_o_pc      <= r_pc;
                        r_o_insn    <= r_insn;
                        if (r_exit == rv64is_pkg::EXIT_RUN) begin
                            r_o_wb  <= r_wb;
                            r_o_rd  <= r_wb ? rd : 5'd0;
                            r_o_val <= (r_wb && rd != 5'd0) ? r_val : 64'd0;
                            r_o_npc <= r_npc;
                            r_pc    <= r_npc;
                            if (rf_we) begin
                                r_rf_vld[rd] <= 1'b1;
                            end
                        end else begin
                            r_o_wb  <= 1'b0;
                            r_o_rd  <= 5'd0;
                            r_o_val <= 64'd0;
                            r_o_npc <= r_pc;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_exit_code   = r_o_exit;
    assign o_insn_pc     = r_o_pc;
    assign o_insn_word   = r_o_insn;
    assign o_reg_written = r_o_wb;
    assign o_dest_index  = r_o_rd;
    assign o_dest_value  = r_o_val;
    assign o_next_pc     = r_o_npc;

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> rf_waddr != 5'd0)
        else $error("register file write to x0");

    a_exit_holds_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_exit_code != rv64is_pkg::EXIT_RUN) |->
            (!o_reg_written && o_next_pc == o_insn_pc))
        else $error("exit result moved pc or wrote back");

    a_mem_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_IMG || r_state == S_STORE))
        else $error("byte memory written outside a write phase");

    a_md_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_md_start |-> r_state == S_MD && $past(r_state) == S_EXEC)
        else $error("muldiv start outside execute");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the RV64IM step unit: directed corner cases, then random programs.
`timescale 1ns/1ps
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rv64is_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int DRAIN_CYCLES   = 400;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_DIVU = 3'd5;
    localparam logic [2:0] F3_REMU = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_LWU  = 3'd6;
    localparam logic [2:0] F3_SD   = 3'd3;
    localparam logic       FUNC_IMAGE = 1'b0;
    localparam logic       FUNC_EXEC  = 1'b1;

    typedef struct packed {
        t_exit       exit_code;
        logic [63:0] insn_pc;
        logic [31:0] insn_word;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [63:0] dest_value;
        logic [63:0] next_pc;
    } step_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_func = 1'b0;
    logic [15:0] i_image_addr = '0;
    logic [63:0] i_image_word = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_exit_code;
    logic [63:0] o_insn_pc;
    logic [31:0] o_insn_word;
    logic        o_reg_written;
    logic [4:0]  o_dest_index;
    logic [63:0] o_dest_value;
    logic [63:0] o_next_pc;

    rv64im_instruction_step_unit u_top (.*);

    always #4 i_clk = ~i_clk;

    // shadow of the core state
    logic [7:0]   shadow_mem [0:65535];
    logic [63:0]  shadow_regs [32];
    logic [63:0]  shadow_pc;
    step_result_t pending_steps [$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;

    function automatic logic [63:0] mem_read(input logic [63:0] a, input int nbytes);
        logic [63:0] v;
        logic [15:0] ad;
        v = '0;
        for (int i = 0; i < nbytes; i++) begin
            ad = a[15:0] + 16'(i);
            v[8*i +: 8] = shadow_mem[ad];
        end
        return v;
    endfunction

    function automatic void mem_write(input logic [63:0] a, input logic [63:0] v,
                                      input int nbytes);
        logic [15:0] ad;
        for (int i = 0; i < nbytes; i++) begin
            ad = a[15:0] + 16'(i);
            shadow_mem[ad] = v[8*i +: 8];
        end
    endfunction

    function automatic logic [63:0] signed_div64(input logic [63:0] a, input logic [63:0] b,
                                                 input logic want_rem);
        logic [63:0] ma, mb, q, r;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (want_rem) return a[63] ? -r : r;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [31:0] signed_div32(input logic [31:0] a, input logic [31:0] b,
                                                 input logic want_rem);
        logic [31:0] ma, mb, q, r;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (want_rem) return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic step_result_t predict_step(input logic f, input logic [15:0] ia,
                                                  input logic [63:0] iw);
        step_result_t r;
        logic [31:0]  w, aw, bw;
        logic [6:0]   op, f7;
        logic [4:0]   rd, rs1;
        logic [2:0]   f3;
        logic [63:0]  a, b, ii, si, bi, ui, ji, npc, val, ld;
        logic [127:0] prod;
        logic         wb, ill, taken;
        r = '0;
        r.insn_pc = shadow_pc;
        r.next_pc = shadow_pc;
        if (f == FUNC_IMAGE) begin
            mem_write({48'd0, ia}, iw, 8);
            return r;
        end
        shadow_regs[0] = '0;
        w = mem_read(shadow_pc, 4);
        op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; f7 = w[31:25];
        a = shadow_regs[rs1];
        b = shadow_regs[w[24:20]];
        aw = a[31:0];
        bw = b[31:0];
        ii = {{52{w[31]}}, w[31:20]};
        si = {{52{w[31]}}, w[31:25], w[11:7]};
        bi = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        ui = {{32{w[31]}}, w[31:12], 12'd0};
        ji = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        npc = shadow_pc + 64'd4;
        val = '0;
        wb = 1'b0;
        ill = 1'b0;
        r.insn_word = w;
        case (op)
            OP_LUI: begin wb = 1; val = ui; end
            OP_AUIPC: begin wb = 1; val = shadow_pc + ui; end
            OP_JAL: begin wb = 1; val = shadow_pc + 64'd4; npc = shadow_pc + ji; end
            OP_JALR: begin
                if (f3 != 3'd0) ill = 1;
                else begin
                    wb = 1; val = shadow_pc + 64'd4; npc = (a + ii) & ~64'd1;
                end
            end
            OP_BRANCH: begin
                taken = 1'b0;
                case (f3)
                    F3_BEQ:  taken = (a == b);
                    F3_BNE:  taken = (a != b);
                    F3_BLT:  taken = ($signed(a) < $signed(b));
                    F3_BGE:  taken = !($signed(a) < $signed(b));
                    F3_BLTU: taken = (a < b);
                    F3_BGEU: taken = (a >= b);
                    default: ill = 1;
                endcase
                if (taken) npc = shadow_pc + bi;
            end
            OP_LOAD: begin
                wb = 1;
                ld = mem_read(a + ii, 8);
                case (f3)
                    F3_LB:   val = {{56{ld[7]}}, ld[7:0]};
                    F3_LH:   val = {{48{ld[15]}}, ld[15:0]};
                    F3_LW:   val = {{32{ld[31]}}, ld[31:0]};
                    F3_LD:   val = ld;
                    F3_LBU:  val = {56'd0, ld[7:0]};
                    F3_LHU:  val = {48'd0, ld[15:0]};
                    F3_LWU:  val = {32'd0, ld[31:0]};
                    default: ill = 1;
                endcase
            end
            OP_STORE: begin
                if (f3 > F3_SD) ill = 1;
                else mem_write(a + si, b, 1 << f3);
            end
            OP_IMM: begin
                wb = 1;
                case (f3)
                    F3_ADD:  val = a + ii;
                    F3_SLT:  val = {63'd0, $signed(a) < $signed(ii)};
                    F3_SLTU: val = {63'd0, a < ii};
                    F3_XOR:  val = a ^ ii;
                    F3_OR:   val = a | ii;
                    F3_AND:  val = a & ii;
                    F3_SLL: begin
                        if (f7[6:1] != 6'd0) ill = 1; else val = a << w[25:20];
                    end
                    default: begin
                        if (f7[6:1] == 6'd0) val = a >> w[25:20];
                        else if (f7[6:1] == F6_ALT) val = $signed(a) >>> w[25:20];
                        else ill = 1;
                    end
                endcase
            end
            OP_REG: begin
                wb = 1;
                if (f7 == F7_MULDIV) begin
                    case (f3)
                        F3_MUL: val = a * b;
                        F3_MULH: begin
                            prod = {{64{a[63]}}, a} * {{64{b[63]}}, b}; val = prod[127:64];
                        end
                        F3_MULHSU: begin
                            prod = {{64{a[63]}}, a} * {64'd0, b}; val = prod[127:64];
                        end
                        F3_MULHU: begin
                            prod = {64'd0, a} * {64'd0, b}; val = prod[127:64];
                        end
                        F3_DIV:  val = (b == 0) ? '1 : signed_div64(a, b, 1'b0);
                        F3_DIVU: val = (b == 0) ? '1 : a / b;
                        F3_REM:  val = (b == 0) ? a : signed_div64(a, b, 1'b1);
                        default: val = (b == 0) ? a : a % b;
                    endcase
                end else if (f7 == F7_ALT) begin
                    if (f3 == F3_ADD) val = a - b;
                    else if (f3 == F3_SRL) val = $signed(a) >>> b[5:0];
                    else ill = 1;
                end else if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  val = a + b;
                        F3_SLL:  val = a << b[5:0];
                        F3_SLT:  val = {63'd0, $signed(a) < $signed(b)};
                        F3_SLTU: val = {63'd0, a < b};
                        F3_XOR:  val = a ^ b;
                        F3_SRL:  val = a >> b[5:0];
                        F3_OR:   val = a | b;
                        default: val = a & b;
                    endcase
                end else ill = 1;
            end
            OP_FENCE: ;
            OP_SYSTEM: begin
                if (f3 != 3'd0 || rs1 != 5'd0 || rd != 5'd0) ill = 1;
                else if (ii == 64'd0) r.exit_code = EXIT_ECALL;
                else if (ii == 64'd1) r.exit_code = EXIT_EBREAK;
                else ill = 1;
            end
            OP_IMM32: begin
                wb = 1;
                if (f3 == F3_ADD) val = sext32(aw + ii[31:0]);
                else if (f3 == F3_SLL && f7 == F7_BASE) val = sext32(aw << w[24:20]);
                else if (f3 == F3_SRL && f7 == F7_BASE) val = sext32(aw >> w[24:20]);
                else if (f3 == F3_SRL && f7 == F7_ALT) val = sext32($signed(aw) >>> w[24:20]);
                else ill = 1;
            end
            OP_REG32: begin
                wb = 1;
                if (f7 == F7_MULDIV) begin
                    case (f3)
                        F3_MUL:  val = sext32(aw * bw);
                        F3_DIV:  val = (bw == 0) ? '1 : sext32(signed_div32(aw, bw, 1'b0));
                        F3_DIVU: val = (bw == 0) ? '1 : sext32(aw / bw);
                        F3_REM:  val = sext32((bw == 0) ? aw : signed_div32(aw, bw, 1'b1));
                        F3_REMU: val = sext32((bw == 0) ? aw : aw % bw);
                        default: ill = 1;
                    endcase
                end else if (f7 == F7_BASE) begin
                    if (f3 == F3_ADD) val = sext32(aw + bw);
                    else if (f3 == F3_SLL) val = sext32(aw << bw[4:0]);
                    else if (f3 == F3_SRL) val = sext32(aw >> bw[4:0]);
                    else ill = 1;
                end else if (f7 == F7_ALT) begin
                    if (f3 == F3_ADD) val = sext32(aw - bw);
                    else if (f3 == F3_SRL) val = sext32($signed(aw) >>> bw[4:0]);
                    else ill = 1;
                end else ill = 1;
            end
            default: ill = 1;
        endcase
        if (ill) r.exit_code = EXIT_ILLEGAL;
        if (r.exit_code != EXIT_RUN) return r;
        if (wb) begin
            if (rd == 5'd0) val = '0;
            shadow_regs[rd] = val;
            r.reg_written = 1'b1;
            r.dest_index = rd;
            r.dest_value = val;
        end
        shadow_regs[0] = '0;
        shadow_pc = npc;
        r.next_pc = npc;
        return r;
    endfunction

    // valid stays high after a transfer; callers lower it with release_valid before waiting
    task automatic send_item(input logic f, input logic [15:0] a, input logic [63:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_image_addr <= a;
        i_image_word <= w;
        do @(posedge i_clk); while (o_stall);
        pending_steps.push_back(predict_step(f, a, w));
    endtask

    task automatic release_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        release_valid();
        while (pending_steps.size() != 0) @(posedge i_clk);
    endtask

    // place an instruction at pc, then execute it
    task automatic run_insn(input logic [31:0] insn);
        send_item(FUNC_IMAGE, shadow_pc[15:0], {$urandom(), insn});
        send_item(FUNC_EXEC, $urandom(), {$urandom(), $urandom()});
    endtask

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
            input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd,
            input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
            input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return 64'd1;
            2: return '1;
            3: return 64'h8000_0000_0000_0000;
            4: return 64'h7fff_ffff_ffff_ffff;
            5: return {$urandom_range(1) ? 32'hffff_ffff : 32'd0, 32'h8000_0000};
            6: return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // load an arbitrary value into a register through a doubleword in the top 2 KiB
    task automatic load_register(input logic [4:0] rd, input logic [63:0] v);
        logic [11:0] off;
        off = 12'h800 + 12'($urandom_range(255) * 8);
        send_item(FUNC_IMAGE, {4'hf, off}, v);
        run_insn(enc_i(off, 5'd0, F3_LD, rd, OP_LOAD));
    endtask

    function automatic logic [6:0] pick_f7();
        case ($urandom_range(7))
            0, 1, 2: return F7_BASE;
            3, 4:    return F7_ALT;
            5, 6:    return F7_MULDIV;
            default: return 7'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] random_insn();
        logic [4:0]  rd, rs1, rs2;
        logic [11:0] imm;
        logic [20:0] jimm;
        logic [12:0] bimm;
        logic [2:0]  f3;
        rd = 5'($urandom()); rs1 = 5'($urandom()); rs2 = 5'($urandom());
        imm = 12'($urandom());
        f3 = 3'($urandom());
        case ($urandom_range(15))
            0: return {20'($urandom()), rd, $urandom_range(1) ? OP_LUI : OP_AUIPC};
            1: begin
                jimm = $urandom_range(1) ? 21'($urandom()) : 21'($signed(12'($urandom())));
                return {jimm[20], jimm[10:1], jimm[11], jimm[19:12], rd, OP_JAL};
            end
            2: return enc_i(imm, rs1, ($urandom_range(7) == 0) ? f3 : 3'd0, rd, OP_JALR);
            3: begin
                bimm = 13'($urandom());
                return {bimm[12], bimm[10:5], rs2, rs1, f3, bimm[4:1], bimm[11], OP_BRANCH};
            end
            4: return enc_i(imm, rs1, f3, rd, OP_LOAD);
            5: begin
                if ($urandom_range(7) != 0) f3 = 3'($urandom_range(3));
                return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
            end
            6, 7: begin
                if (f3 == F3_SLL || f3 == F3_SRL)
                    imm = {pick_f7()[6:1], 6'($urandom())};
                return enc_i(imm, rs1, f3, rd, OP_IMM);
            end
            8, 9: return enc_r(pick_f7(), rs2, rs1, f3, rd, OP_REG);
            10: begin
                if (f3 == F3_SLL || f3 == F3_SRL) imm = {pick_f7(), 5'($urandom())};
                return enc_i(imm, rs1, f3, rd, OP_IMM32);
            end
            11, 12: return enc_r(pick_f7(), rs2, rs1, f3, rd, OP_REG32);
            13: return {25'($urandom()), OP_FENCE};
            14: begin
                if ($urandom_range(3) == 0) return enc_i(imm, rs1, f3, rd, OP_SYSTEM);
                return enc_i(12'($urandom_range(1)), 5'd0, 3'd0, 5'd0, OP_SYSTEM);
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic test_reset_state();
        send_item(FUNC_EXEC, 16'h0000, '0);
        send_item(FUNC_IMAGE, 16'hfffc, 64'h8899_aabb_ccdd_eeff);
        run_insn(enc_i(12'hffc, 5'd0, F3_LD, 5'd1, OP_LOAD));
    endtask

    task automatic test_muldiv_corners();
        run_insn(enc_i(12'hfff, 5'd0, F3_ADD, 5'd2, OP_IMM));
        run_insn(enc_i(12'd1, 5'd0, F3_ADD, 5'd3, OP_IMM));
        run_insn(enc_i(12'd63, 5'd3, F3_SLL, 5'd3, OP_IMM));
        run_insn(enc_r(F7_MULDIV, 5'd2, 5'd3, F3_DIV, 5'd4, OP_REG));
        run_insn(enc_r(F7_MULDIV, 5'd2, 5'd3, F3_REM, 5'd5, OP_REG));
        run_insn(enc_r(F7_MULDIV, 5'd0, 5'd3, F3_DIVU, 5'd6, OP_REG));
        run_insn(enc_r(F7_MULDIV, 5'd0, 5'd2, F3_REMU, 5'd7, OP_REG32));
        run_insn(enc_r(F7_MULDIV, 5'd2, 5'd3, F3_MULH, 5'd8, OP_REG));
    endtask

    task automatic test_memory_and_jumps();
        run_insn(enc_i(12'd5, 5'd0, F3_ADD, 5'd0, OP_IMM));
        run_insn({7'h7f, 5'd2, 5'd0, F3_SD, 5'h1d, OP_STORE});
        run_insn(enc_i(12'h7fd, 5'd0, F3_LWU, 5'd9, OP_LOAD));
        run_insn(enc_i(12'd7, 5'd0, 3'd0, 5'd10, OP_JALR));
    endtask

    task automatic test_exits();
        run_insn(enc_i(12'd0, 5'd0, 3'd0, 5'd0, OP_SYSTEM));
        send_item(FUNC_EXEC, '0, '0);
        run_insn(enc_i(12'd1, 5'd0, 3'd0, 5'd0, OP_SYSTEM));
    endtask

    task automatic test_random_programs(input int n_items, input int idle_pct,
                                        input int stall_prob);
        int sent;
        send_idle_pct = idle_pct;
        stall_pct = stall_prob;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(19))
                0: begin
                    send_item(FUNC_IMAGE, 16'($urandom()), {$urandom(), $urandom()});
                    sent += 1;
                end
                1, 2: begin
                    load_register(5'($urandom()), pick_value());
                    sent += 3;
                end
                3: begin
                    send_item(FUNC_EXEC, 16'($urandom()), {$urandom(), $urandom()});
                    sent += 1;
                end
                default: begin
                    run_insn(random_insn());
                    sent += 2;
                end
            endcase
        end
        // hold off until the core has drained
        wait_all_results();
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        step_result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_steps.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual pc %h word %h",
                         $time, o_insn_pc, o_insn_word);
                error_count++;
            end else begin
                e = pending_steps.pop_front();
                check_field("exit_code", e.exit_code, o_exit_code);
                check_field("insn_pc", e.insn_pc, o_insn_pc);
                check_field("insn_word", e.insn_word, o_insn_word);
                check_field("reg_written", e.reg_written, o_reg_written);
                check_field("dest_index", e.dest_index, o_dest_index);
                check_field("dest_value", e.dest_value, o_dest_value);
                check_field("next_pc", e.next_pc, o_next_pc);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        foreach (shadow_mem[i]) shadow_mem[i] = 8'd0;
        foreach (shadow_regs[i]) shadow_regs[i] = 64'd0;
        shadow_pc = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_muldiv_corners();
        test_memory_and_jumps();
        test_exits();
        wait_all_results();
        test_random_programs(140, 0, 0);
        test_random_programs(140, 83, 0);
        test_random_programs(140, 0, 83);
        test_random_programs(140, 18, 18);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_steps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (pending_steps.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_steps.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rv64is_pkg.sv
sv/rv64is_ram.sv
sv/rv64is_muldiv.sv
sv/rv64im_instruction_step_unit.sv
tb/testbench.sv
